/* design/square_matrix_multiply_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef SQUARE_MATRIX_MULTIPLY_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/smm_pkg.sv */
package smm_pkg;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam int ELEM_W = 16;
  localparam int MUL_W  = 32;
  localparam int ACC_W  = 40;
  localparam int IDX_W  = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } smm_state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic next_col;
    logic emit;
  } smm_cmd_t;

  typedef struct packed {
    logic k_last;
    logic j_last;
    logic pipe_busy;
    logic out_free;
  } smm_status_t;

endpackage

/* design/smm_ctrl.sv */
module smm_ctrl import smm_pkg::*; #(
  parameter int DIM = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  input  logic [IDX_W-1:0]    in_row,
  input  logic [IDX_W-1:0]    in_col,
  output logic                in_stall,
  input  smm_status_t         status,
  output smm_cmd_t            cmd
);

  smm_state_t state_r, state_nxt;
  logic       row_ok, col_ok;

  assign row_ok = 32'(in_row) < DIM;
  assign col_ok = 32'(in_col) < DIM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_COMPUTE && row_ok) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (status.k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = status.j_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.wr_a  = in_valid && in_op == OP_LOAD_A && row_ok && col_ok;
        cmd.wr_b  = in_valid && in_op == OP_LOAD_B && row_ok && col_ok;
        cmd.start = in_valid && in_op == OP_COMPUTE && row_ok;
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_EMIT: begin
        cmd.emit     = status.out_free;
        cmd.next_col = status.out_free && !status.j_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* design/smm_datapath.sv */
module smm_datapath import smm_pkg::*; #(
  parameter int DIM = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [ELEM_W-1:0] in_value,
  input  smm_cmd_t                 cmd,
  output smm_status_t              status,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ACC_W-1:0]  out_product,
  output logic                     out_last
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  logic [IW-1:0] row_r, k_r, j_r;
  logic          k_last, j_last;

  logic signed [ELEM_W-1:0] a_q_r, b_q_r;
  logic                     v1_r, v2_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [ACC_W-1:0] out_product_r;
  logic                    out_last_r;

  assign wr_addr   = AW'(32'(in_row) * DIM + 32'(in_col));
  assign rd_addr_a = AW'(32'(row_r) * DIM + 32'(k_r));
  assign rd_addr_b = AW'(32'(k_r) * DIM + 32'(j_r));

  assign k_last = k_r == IW'(DIM - 1);
  assign j_last = j_r == IW'(DIM - 1);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= in_value;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= in_value;
    end
    a_q_r <= mem_a[rd_addr_a];
    b_q_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      k_r   <= '0;
      j_r   <= '0;
    end else begin
      if (cmd.start) begin
        row_r <= IW'(in_row);
        k_r   <= '0;
        j_r   <= '0;
      end else begin
        if (cmd.issue) begin
          k_r <= k_last ? '0 : k_r + 1'b1;
        end
        if (cmd.next_col) begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  // Read, multiply and accumulate stages, tagged with valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= a_q_r * b_q_r;
    if (cmd.issue && k_r == '0) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  assign status.k_last    = k_last;
  assign status.j_last    = j_last;
  assign status.pipe_busy = v1_r || v2_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r     <= IDX_W'(row_r);
      out_col_r     <= IDX_W'(j_r);
      out_product_r <= acc_r;
      out_last_r    <= j_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_product = out_product_r;
  assign out_last    = out_last_r;

endmodule

/* design/square_matrix_multiply.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_op, in_row, in_col, in_value
// out     | output    | out_valid/out_stall| out_row, out_col, out_product, out_last
//
// A load beat is taken while the block is idle; a compute beat holds the input until
// its row is done, plus any output stall: for each column, DIM reads through the
// single multiply-accumulate, pipeline drain, then the column goes to the output.
// Reset clears control only; matrix storage holds garbage until loaded.
// A stalled output keeps its beat while the next input beat is taken.
module square_matrix_multiply import smm_pkg::*; #(
  parameter int DIM = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [ELEM_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ACC_W-1:0]  out_product,
  output logic                     out_last
);

  smm_cmd_t    cmd;
  smm_status_t status;

  smm_ctrl #(.DIM(DIM)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smm_datapath #(.DIM(DIM)) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_product (out_product),
    .out_last    (out_last)
  );

endmodule

/* design/smm_checker.sv */
`include "square_matrix_multiply_macros.svh"

module smm_checker import smm_pkg::*; #(
  parameter int DIM = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [1:0]               in_op,
  input logic [IDX_W-1:0]         in_row,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [IDX_W-1:0]         out_col,
  input logic signed [ACC_W-1:0]  out_product,
  input logic                     out_last
);

  `SMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_product) && $stable(out_col), "stalled output beat changed")
  `SMM_ASSERT_NEXT(a_compute_busy, in_valid && !in_stall && in_op == OP_COMPUTE && 32'(in_row) < DIM, in_stall, "input not held after compute beat")
  `SMM_ASSERT_SAME(a_row_continues, out_valid && !out_last, in_stall, "input taken in the middle of a result row")
  `SMM_ASSERT_SAME(a_last_col, out_valid && out_last, out_col == IDX_W'(DIM - 1), "last flag on wrong column")

endmodule

bind square_matrix_multiply smm_checker #(.DIM(DIM)) u_smm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_op       (in_op),
  .in_row      (in_row),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_col     (out_col),
  .out_product (out_product),
  .out_last    (out_last)
);

/* tb/tb.sv */
module tb;
  import smm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 24;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int HOLDOFF_AFTER = 20;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     sync;
  } mm_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] product;
    logic                    last;
  } mm_elem_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = OP_LOAD_A;
  logic [IDX_W-1:0]         in_row = '0;
  logic [IDX_W-1:0]         in_col = '0;
  logic signed [ELEM_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [ACC_W-1:0]  out_product;
  logic                     out_last;

  logic signed [ELEM_W-1:0] mat_a [DIM][DIM];
  logic signed [ELEM_W-1:0] mat_b [DIM][DIM];

  mm_beat_t stim_beats[$];
  mm_elem_t pending_products[$];
  mm_beat_t cur_beat;

  int err_count = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_tick = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  square_matrix_multiply #(.DIM(DIM)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_product (out_product),
    .out_last    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  function automatic void add_beat(logic [1:0] op, int row, int col,
                                   logic signed [ELEM_W-1:0] value, logic sync);
    mm_beat_t b;
    b.op = op;
    b.row = IDX_W'(row);
    b.col = IDX_W'(col);
    b.value = value;
    b.sync = sync;
    stim_beats.push_back(b);
  endfunction

  // Update the matrix copies on loads; queue one dot product per column on compute.
  function automatic void apply_matrix_beat(mm_beat_t b);
    logic signed [ACC_W-1:0] acc;
    logic signed [2*ELEM_W-1:0] term;
    mm_elem_t e;
    case (b.op)
      OP_LOAD_A: if (b.row < DIM && b.col < DIM) mat_a[b.row][b.col] = b.value;
      OP_LOAD_B: if (b.row < DIM && b.col < DIM) mat_b[b.row][b.col] = b.value;
      OP_COMPUTE: begin
        if (b.row < DIM) begin
          for (int j = 0; j < DIM; j++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
              term = mat_a[b.row][k] * mat_b[k][j];
              acc = acc + term;
            end
            e.row = b.row;
            e.col = IDX_W'(j);
            e.product = acc;
            e.last = (j == DIM - 1);
            pending_products.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: bursts of beats with random gaps; a sync beat waits for an empty pipe.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) apply_matrix_beat(cur_beat);
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_beats.size() != 0 &&
                   (!stim_beats[0].sync || pending_products.size() == 0)) begin
        cur_beat = stim_beats.pop_front();
        in_valid <= 1'b1;
        in_op <= cur_beat.op;
        in_row <= cur_beat.row;
        in_col <= cur_beat.col;
        in_value <= cur_beat.value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
      out_stall <= 1'b1;
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
    end else begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[11:10])
        2'd0: out_stall <= 1'b0;
        2'd3: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ($urandom_range(0, 99) < 30);
      endcase
    end
  end

  always @(posedge clk) begin : check_out
    mm_elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected beat row %0d col %0d product %0d last %0b",
                 $time, out_row, out_col, out_product, out_last);
        err_count++;
      end else begin
        want = pending_products.pop_front();
        if (out_row !== want.row) begin
          $display("%0t: out_row mismatch, expected %0d got %0d", $time, want.row, out_row);
          err_count++;
        end
        if (out_col !== want.col) begin
          $display("%0t: out_col mismatch, expected %0d got %0d", $time, want.col, out_col);
          err_count++;
        end
        if (out_product !== want.product) begin
          $display("%0t: out_product mismatch (row %0d col %0d), expected %0d got %0d",
                   $time, want.row, want.col, want.product, out_product);
          err_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last mismatch, expected %0b got %0b", $time, want.last, out_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    int sel;
    // Fill all of B and rows 0 and DIM-1 of A; computes only name those two rows,
    // so none ever reads an unwritten entry.
    // Row 0 of A and columns 0..2 of B carry extreme patterns.
    for (int c = 0; c < DIM; c++)
      add_beat(OP_LOAD_A, 0, c, 16'sh8000, 1'b0);
    for (int c = 0; c < DIM; c++)
      add_beat(OP_LOAD_A, DIM - 1, c,
               (c < DIM / 2) ? ((c % 2 == 0) ? 16'sh8000 : 16'sh7FFF) : pick_value(),
               1'b0);
    for (int k = 0; k < DIM; k++)
      for (int j = 0; j < DIM; j++)
        add_beat(OP_LOAD_B, k, j,
                 (j == 0) ? 16'sh8000 : (j == 1) ? 16'sh7FFF :
                 (j == 2) ? 16'sh0000 : pick_value(), 1'b0);

    // Directed: extreme dot products, ignored op, overwrites, last row.
    add_beat(OP_COMPUTE, 0, 0, 16'sh0000, 1'b0);
    add_beat(OP_COMPUTE, 15, 15, 16'sh7FFF, 1'b0);
    add_beat(OP_UNUSED, 15, 15, 16'shFFFF, 1'b0);
    add_beat(OP_UNUSED, 0, 0, 16'sh0000, 1'b0);
    add_beat(OP_LOAD_A, 15, 15, 16'sh7FFF, 1'b0);
    add_beat(OP_LOAD_B, 15, 15, 16'sh8000, 1'b0);
    add_beat(OP_LOAD_A, 15, 0, 16'sh0001, 1'b0);
    add_beat(OP_LOAD_B, 0, 15, 16'shFFFF, 1'b0);
    add_beat(OP_COMPUTE, 15, 0, 16'sh0000, 1'b0);
    add_beat(OP_LOAD_A, 0, 3, 16'shFFFF, 1'b0);
    add_beat(OP_LOAD_B, 3, 3, 16'sh0100, 1'b0);
    add_beat(OP_COMPUTE, 0, 7, 16'sh1234, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5)
        add_beat(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
                 i % 8 == 0);
      else if (sel < 50)
        add_beat((sel < 28) ? OP_LOAD_A : OP_LOAD_B, $urandom_range(0, DIM - 1),
                 $urandom_range(0, DIM - 1), pick_value(), i % 8 == 0);
      else
        add_beat(OP_COMPUTE, ($urandom_range(0, 1) == 0) ? 0 : DIM - 1,
                 $urandom_range(0, 15), ELEM_W'($urandom()), i % 8 == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_beats.size() != 0 || in_valid) @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("square_matrix_multiply regression: pass");
    end else begin
      $display("square_matrix_multiply regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("square_matrix_multiply regression: fail");
    $finish;
  end

endmodule
